FILE: src/lru_key_value_cache_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LKVC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lkvc_pkg.sv
// Shared constants and types of the LRU key/value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	typedef enum logic [1:0] {
		DIR_NOP,
		DIR_TOUCH,
		DIR_EVICT,
		DIR_INSERT
	} dir_op_t;

	typedef struct packed {
		dir_op_t          op;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] limit;
	} dir_req_t;

	typedef struct packed {
		logic [ENTRIES-1:0] valid;
		logic [IDX_W-1:0]   free_slot;
		logic               free_found;
		logic [CNT_W-1:0]   occupancy;
	} dir_stat_t;

endpackage

FILE: src/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: src/lkvc_dir.sv
// Entry directory: valid marks, recency ranks, occupancy and free-slot search.
`timescale 1ns / 1ps
module lkvc_dir (
	input  logic               clk,
	input  logic               arst_n,
	input  lkvc_pkg::dir_req_t req,
	output lkvc_pkg::dir_stat_t stat
);

	logic [lkvc_pkg::ENTRIES-1:0]  valid_q;
	logic [lkvc_pkg::RANK_W-1:0]   rank_q [lkvc_pkg::ENTRIES];
	logic [lkvc_pkg::CNT_W-1:0]    occ_q;
	logic [lkvc_pkg::RANK_W-1:0]   touch_rank;
	logic [lkvc_pkg::IDX_W-1:0]    free_slot;
	logic                          free_found;

	assign touch_rank = rank_q[req.slot];

	// Lowest-numbered invalid entry takes the next insertion.
	always_comb begin
		free_slot  = '0;
		free_found = 1'b0;
		for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot  = lkvc_pkg::IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			case (req.op)
				lkvc_pkg::DIR_TOUCH: begin
					for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
						if (lkvc_pkg::IDX_W'(i) == req.slot) begin
							rank_q[i] <= '0;
						end else if (valid_q[i] && rank_q[i] < touch_rank) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
				end
				lkvc_pkg::DIR_EVICT: begin
					// Drop every entry ranked beyond the last rank kept.
					for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
						if (valid_q[i] && lkvc_pkg::CNT_W'(rank_q[i]) >= req.limit) begin
							valid_q[i] <= 1'b0;
							rank_q[i]  <= '0;
						end
					end
					occ_q <= req.limit;
				end
				lkvc_pkg::DIR_INSERT: begin
					if (free_found) begin
						for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
							if (lkvc_pkg::IDX_W'(i) == free_slot) begin
								valid_q[i] <= 1'b1;
								rank_q[i]  <= '0;
							end else if (valid_q[i]) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						occ_q <= occ_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.valid      = valid_q;
	assign stat.free_slot  = free_slot;
	assign stat.free_found = free_found;
	assign stat.occupancy  = occ_q;

endmodule

FILE: src/lru_key_value_cache.sv
// Top level of the LRU key/value cache: request sequencer and shared key comparator.
//
// Requests enter on the s_ group: s_tuser is the command (0 get, 1 set),
// s_tdata carries the key and the value to store. Each request gives one
// result on the m_ group: m_tuser is the hit flag, m_tdata the read value
// (stored value on a get hit, all ones on a get miss, zero on any set).
// The user must write the capacity register on the cfg_ group only while no
// request is in progress; the block does not enforce it. 0 acts as 1 and
// values above the entry count act as it. One 32-bit comparator walks the
// stored keys one entry a cycle, then a final compare and a decide step run;
// a set that misses adds an insert step, after an evict step when occupancy
// has reached the capacity, before the response step that ends every request.
// s_tready is high only while the sequencer is idle. A finished result is
// held in the output register; the next request may be accepted while it
// waits, but that request's result waits until the receiver takes the old one.
// Reset clears all valid marks, occupancy and recency; no clearing pass runs,
// so the first request can be accepted right after reset.
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"
module lru_key_value_cache (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data,   // capacity
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,    // lookup_key[31:0], write_value[63:32]
	input  logic                         s_tuser,    // command
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lkvc_pkg::VAL_W-1:0]   m_tdata,    // read_value
	output logic                         m_tuser     // hit
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_EVICT,
		ST_INSERT,
		ST_RESP
	} state_t;

	state_t                          state_q;
	logic [lkvc_pkg::CAP_W-1:0]      cap_q;
	logic                            cmd_q;
	logic [lkvc_pkg::KEY_W-1:0]      key_q;
	logic [lkvc_pkg::VAL_W-1:0]      wval_q;
	logic [lkvc_pkg::IDX_W-1:0]      idx_q;
	logic                            cmp_v_s1;
	logic [lkvc_pkg::IDX_W-1:0]      idx_s1;
	logic                            hit_q;
	logic [lkvc_pkg::IDX_W-1:0]      slot_q;
	logic [lkvc_pkg::VAL_W-1:0]      val_q;
	logic                            m_tvalid_q;
	logic [lkvc_pkg::VAL_W-1:0]      m_tdata_q;
	logic                            m_tuser_q;

	logic [lkvc_pkg::CNT_W-1:0]      eff_cap;
	logic [lkvc_pkg::KEY_W-1:0]      key_rdata;
	logic [lkvc_pkg::VAL_W-1:0]      val_rdata;
	logic                            key_wr_en;
	logic                            val_wr_en;
	logic [lkvc_pkg::IDX_W-1:0]      wr_slot;
	logic                            match;
	lkvc_pkg::dir_req_t              dir_req;
	lkvc_pkg::dir_stat_t             dir_stat;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkvc_pkg::CNT_W'(1);
		end else if (32'(cap_q) > 32'(lkvc_pkg::ENTRIES)) begin
			eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
		end else begin
			eff_cap = lkvc_pkg::CNT_W'(cap_q);
		end
	end

	// Keys and values are read at the scan index; read data arrives in the cycle after the index.
	lkvc_ram #(.WIDTH(lkvc_pkg::KEY_W), .DEPTH(lkvc_pkg::ENTRIES)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr_en),
		.wr_addr (wr_slot),
		.wr_data (key_q),
		.rd_addr (idx_q),
		.rd_data (key_rdata)
	);

	lkvc_ram #(.WIDTH(lkvc_pkg::VAL_W), .DEPTH(lkvc_pkg::ENTRIES)) u_val_ram (
		.clk     (clk),
		.wr_en   (val_wr_en),
		.wr_addr (wr_slot),
		.wr_data (wval_q),
		.rd_addr (idx_q),
		.rd_data (val_rdata)
	);

	lkvc_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dir_req),
		.stat   (dir_stat)
	);

	assign match = cmp_v_s1 && dir_stat.valid[idx_s1] && (key_rdata == key_q);

	always_comb begin
		dir_req.op    = lkvc_pkg::DIR_NOP;
		dir_req.slot  = slot_q;
		dir_req.limit = eff_cap - 1'b1;
		key_wr_en     = 1'b0;
		val_wr_en     = 1'b0;
		wr_slot       = slot_q;
		case (state_q)
			ST_DECIDE: begin
				if (cmd_q == lkvc_pkg::CMD_SET && hit_q) begin
					dir_req.op = lkvc_pkg::DIR_TOUCH;
					val_wr_en  = 1'b1;
				end
			end
			ST_EVICT: begin
				dir_req.op = lkvc_pkg::DIR_EVICT;
			end
			ST_INSERT: begin
				dir_req.op = lkvc_pkg::DIR_INSERT;
				wr_slot    = dir_stat.free_slot;
				key_wr_en  = dir_stat.free_found;
				val_wr_en  = dir_stat.free_found;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= lkvc_pkg::CMD_GET;
			key_q      <= '0;
			wval_q     <= '0;
			idx_q      <= '0;
			cmp_v_s1   <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			slot_q     <= '0;
			val_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == ST_SCAN);
			idx_s1   <= idx_q;
			// The response step drives valid itself when it hands over a result.
			if (m_tvalid_q && m_tready && state_q != ST_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			if (match) begin
				hit_q  <= 1'b1;
				slot_q <= idx_s1;
				val_q  <= val_rdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						key_q   <= s_tdata[31:0];
						wval_q  <= s_tdata[63:32];
						idx_q   <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1)) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (cmd_q == lkvc_pkg::CMD_GET || hit_q) begin
						state_q <= ST_RESP;
					end else if (dir_stat.occupancy >= eff_cap) begin
						state_q <= ST_EVICT;
					end else begin
						state_q <= ST_INSERT;
					end
				end
				ST_EVICT: begin
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= hit_q;
						if (cmd_q == lkvc_pkg::CMD_SET) begin
							m_tdata_q <= '0;
						end else if (hit_q) begin
							m_tdata_q <= val_q;
						end else begin
							m_tdata_q <= {lkvc_pkg::VAL_W{1'b1}};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LKVC_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready,
		state_q == ST_SCAN && idx_q == '0 && !hit_q, "accepted request did not start a scan")
	`LKVC_ASSERT_NOW(a_occ_matches_valid, 1'b1,
		$countones(dir_stat.valid) == 32'(dir_stat.occupancy), "occupancy disagrees with valid marks")
	`LKVC_ASSERT_NOW(a_insert_has_room, dir_req.op == lkvc_pkg::DIR_INSERT,
		dir_stat.free_found, "insertion found no free entry")
	`LKVC_ASSERT_NOW(a_result_from_resp, $rose(m_tvalid),
		$past(state_q) == ST_RESP, "result appeared outside the response step")
	`LKVC_ASSERT_NOW(a_single_match, match,
		!hit_q, "key matched more than one valid entry")

endmodule
